@@ sv/dsf_pkg.sv @@
// Package for the DNA strand framer: sizes, codes, reset primers and the
// job descriptor that passes from the front end to the back end.
// Depends on nothing; the front end, job queue, back end and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

    // Strand geometry.
    localparam int PAYLOAD_LEN = 32;
    localparam int ADDRESS_LEN = 9;
    localparam int PRIMER_LEN  = 20;
    localparam int PRIMER_W    = 2 * PRIMER_LEN;
    localparam int IDX_W       = 2 * ADDRESS_LEN;
    localparam int FILL_W      = $clog2(PAYLOAD_LEN + 1);

    // The beat counter covers the longest section of a strand.
    localparam int MAX_CNT_A   = (PRIMER_LEN > ADDRESS_LEN) ? PRIMER_LEN : ADDRESS_LEN;
    localparam int MAX_CNT     = (MAX_CNT_A > PAYLOAD_LEN) ? MAX_CNT_A : PAYLOAD_LEN;
    localparam int CNT_W       = $clog2(MAX_CNT);

    // Job queue between front and back.
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);

    // Configuration port.
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;
    localparam logic REG_LEFT  = 1'b0;
    localparam logic REG_RIGHT = 1'b1;

    // Primers after reset: ACGTTGCATGTCAGTACGTA and TACGACTGACATGCAACGTT.
    localparam logic [PRIMER_W-1:0] LEFT_RESET  = 40'd119804865644;
    localparam logic [PRIMER_W-1:0] RIGHT_RESET = 40'd850908123247;

    // Input commands.
    localparam logic CMD_PAYLOAD = 1'b0;
    localparam logic CMD_END     = 1'b1;

    // Section codes of the result stream.
    localparam logic [2:0] SEC_LEFT    = 3'd0;
    localparam logic [2:0] SEC_ADDR    = 3'd1;
    localparam logic [2:0] SEC_PAYLOAD = 3'd2;
    localparam logic [2:0] SEC_PAD     = 3'd3;
    localparam logic [2:0] SEC_RIGHT   = 3'd4;

    localparam logic [1:0] NT_A = 2'd0;

    // One classified input item, as the back end plays it out.
    typedef struct packed {
        logic               open_strand;
        logic               has_payload;
        logic [1:0]         nt;
        logic [FILL_W-1:0]  pad_cnt;
        logic               close_strand;
        logic [IDX_W-1:0]   index;
    } job_t;

    // Back end sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEFT,
        PH_ADDR,
        PH_PAYLOAD,
        PH_PAD,
        PH_RIGHT
    } phase_t;

    // Queue status toward the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

`default_nettype wire

@@ sv/dsf_if.sv @@
// Valid/ready channel interfaces of the DNA strand framer: the input item
// channel and the result channel. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dsf_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] nucleotide;

    modport source (output valid, output cmd, output nucleotide, input ready);
    modport sink   (input valid, input cmd, input nucleotide, output ready);
endinterface

interface dsf_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] base;
    logic [2:0] section;
    logic       last;

    modport source (output valid, output base, output section, output last, input ready);
    modport sink   (input valid, input base, input section, input last, output ready);
endinterface

`default_nettype wire

@@ sv/dsf_front.sv @@
// Front end: accepts input items, tracks strand index and fill count and
// turns each item but an end with no open strand into a job descriptor. Depends on dsf_pkg and dsf_if.
`timescale 1ns / 1ps
`default_nettype none

module dsf_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    dsf_item_if.sink                item,
    input  wire dsf_pkg::fifo_stat_t stat,
    output logic                    push,
    output dsf_pkg::job_t           job
);
    import dsf_pkg::*;

    logic [IDX_W-1:0]  index_reg, index_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              accept;

    assign item.ready = !stat.full;
    assign accept     = item.valid && item.ready;

    // Classify the item against the open strand.
    always_comb
    begin
        index_next       = index_reg;
        fill_next        = fill_reg;
        job.open_strand  = (fill_reg == '0);
        job.has_payload  = (item.cmd == CMD_PAYLOAD);
        job.nt           = item.nucleotide;
        job.pad_cnt      = FILL_W'(PAYLOAD_LEN) - fill_reg;
        job.index        = index_reg;
        job.close_strand = 1'b1;
        push             = 1'b0;
        if (item.cmd == CMD_PAYLOAD)
        begin
            job.close_strand = (fill_reg == FILL_W'(PAYLOAD_LEN - 1));
            push             = accept;
            if (accept)
            begin
                if (job.close_strand)
                begin
                    fill_next  = '0;
                    index_next = index_reg + 1'b1;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
        else if (fill_reg != '0)
        begin
            // End of data pads the open strand and closes it.
            push = accept;
            if (accept)
            begin
                fill_next  = '0;
                index_next = index_reg + 1'b1;
            end
        end
    end

    // Strand state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            index_reg <= index_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/dsf_job_fifo.sv @@
// Short job queue between the front and back ends of the strand framer.
// Depends on dsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsf_job_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire dsf_pkg::job_t wr_job,
    input  wire logic          pop,
    output dsf_pkg::job_t      head,
    output dsf_pkg::fifo_stat_t stat
);
    import dsf_pkg::*;

    job_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (PTR_W+1)'(FIFO_DEPTH));

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

@@ sv/dsf_back.sv @@
// Back end: plays each job out as a run of nucleotides through a
// registered output stage. Depends on dsf_pkg and dsf_if.
`timescale 1ns / 1ps
`default_nettype none

module dsf_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [dsf_pkg::PRIMER_W-1:0]  left_primer,
    input  wire logic [dsf_pkg::PRIMER_W-1:0]  right_primer,
    input  wire dsf_pkg::job_t                 head,
    input  wire dsf_pkg::fifo_stat_t           stat,
    output logic                               pop,
    dsf_result_if.source                       result
);
    import dsf_pkg::*;

    phase_t           phase_reg, phase_next, phase_after;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    job_t             job_reg, job_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       base_reg, base_next;
    logic [2:0]       section_reg, section_next;
    logic             last_reg, last_next;
    logic             emit;
    logic             phase_done;
    phase_t           start_phase;
    logic [CNT_W-1:0] start_cnt;

    assign result.valid   = out_valid_reg;
    assign result.base    = base_reg;
    assign result.section = section_reg;
    assign result.last    = last_reg;

    // Last beat of a phase for a given job.
    function automatic logic [CNT_W-1:0] phase_len_m1(input phase_t ph, input job_t j);
        logic [CNT_W-1:0] len;
        begin
            case (ph)
                PH_LEFT:  len = CNT_W'(PRIMER_LEN - 1);
                PH_RIGHT: len = CNT_W'(PRIMER_LEN - 1);
                PH_ADDR:  len = CNT_W'(ADDRESS_LEN - 1);
                PH_PAD:   len = CNT_W'(j.pad_cnt - 1'b1);
                default:  len = '0;
            endcase
            return len;
        end
    endfunction

    // First phase of the job at the head of the queue.
    always_comb
    begin
        if (head.open_strand && head.has_payload)
        begin
            start_phase = PH_LEFT;
        end
        else if (head.has_payload)
        begin
            start_phase = PH_PAYLOAD;
        end
        else
        begin
            start_phase = PH_PAD;
        end
        start_cnt = phase_len_m1(start_phase, head);
    end

    // Phase order within a job.
    always_comb
    begin
        case (phase_reg)
            PH_LEFT:    phase_after = PH_ADDR;
            PH_ADDR:    phase_after = PH_PAYLOAD;
            PH_PAYLOAD: phase_after = job_reg.close_strand ? PH_RIGHT : PH_IDLE;
            PH_PAD:     phase_after = PH_RIGHT;
            default:    phase_after = PH_IDLE;
        endcase
    end

    // Sequencer and output stage.
    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        job_next       = job_reg;
        base_next      = base_reg;
        section_next   = section_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        emit           = (phase_reg != PH_IDLE) && (!out_valid_reg || result.ready);
        phase_done     = (cnt_reg == '0);
        out_valid_next = (out_valid_reg && !result.ready) || emit;

        case (phase_reg)
            PH_LEFT:
            begin
                base_next    = left_primer[2*cnt_reg +: 2];
                section_next = SEC_LEFT;
            end
            PH_ADDR:
            begin
                base_next    = job_reg.index[2*cnt_reg +: 2];
                section_next = SEC_ADDR;
            end
            PH_PAYLOAD:
            begin
                base_next    = job_reg.nt;
                section_next = SEC_PAYLOAD;
            end
            PH_PAD:
            begin
                base_next    = NT_A;
                section_next = SEC_PAD;
            end
            PH_RIGHT:
            begin
                base_next    = right_primer[2*cnt_reg +: 2];
                section_next = SEC_RIGHT;
            end
            default:
            begin
                base_next    = base_reg;
                section_next = section_reg;
            end
        endcase

        if (!emit)
        begin
            base_next    = base_reg;
            section_next = section_reg;
        end
        else
        begin
            last_next = phase_done && (phase_after == PH_IDLE);
        end

        if (phase_reg == PH_IDLE)
        begin
            // Idle: take the next job without a beat.
            if (!stat.empty)
            begin
                pop        = 1'b1;
                job_next   = head;
                phase_next = start_phase;
                cnt_next   = start_cnt;
            end
        end
        else if (emit)
        begin
            if (!phase_done)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            else if (phase_after != PH_IDLE)
            begin
                phase_next = phase_after;
                cnt_next   = phase_len_m1(phase_after, job_reg);
            end
            else if (!stat.empty)
            begin
                // Job finished: chain straight into the next one.
                pop        = 1'b1;
                job_next   = head;
                phase_next = start_phase;
                cnt_next   = start_cnt;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        base_reg    <= base_next;
        section_reg <= section_next;
        last_reg    <= last_next;
    end

endmodule

`default_nettype wire

@@ sv/dna_strand_framer_unit.sv @@
// DNA strand framer top level: APB primer registers, front end, job queue, back end.
// Path: item, front end, job queue, back end sequencer, registered output stage.
// Throughput: one input transaction per cycle into a 4-deep job queue while it is not full;
// the back end emits one nucleotide per cycle while the result sink is ready, and a strand
// of PAYLOAD_LEN items comes out as PAYLOAD_LEN + 49 nucleotides.
// Reset: asynchronous, active low; strand index and fill count clear, primers reload.
`timescale 1ns / 1ps
`default_nettype none

module dna_strand_framer_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    dsf_item_if.sink                          item,
    dsf_result_if.source                      result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dsf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dsf_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dsf_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);
    import dsf_pkg::*;

    logic [PRIMER_W-1:0] left_reg, left_next;
    logic [PRIMER_W-1:0] right_reg, right_next;
    logic                wr_en;
    logic                reg_sel;
    logic                push;
    logic                pop;
    job_t                wr_job;
    job_t                head;
    fifo_stat_t          stat;

    // Register decode: registers lie on 8-byte boundaries.
    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_LEFT:  left_next  = pwdata[PRIMER_W-1:0];
                REG_RIGHT: right_next = pwdata[PRIMER_W-1:0];
                default:   left_next  = left_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (reg_sel)
            REG_LEFT:  prdata = PDATA_W'(left_reg);
            REG_RIGHT: prdata = PDATA_W'(right_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= LEFT_RESET;
            right_reg <= RIGHT_RESET;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    dsf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .stat  (stat),
        .push  (push),
        .job   (wr_job)
    );

    dsf_job_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .head   (head),
        .stat   (stat)
    );

    dsf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .left_primer  (left_reg),
        .right_primer (right_reg),
        .head         (head),
        .stat         (stat),
        .pop          (pop),
        .result       (result)
    );

endmodule

`default_nettype wire
